### hdl/tcce_pkg.sv
// shared types, constants and helpers of the text console cursor engine
`default_nettype none

package tcce_pkg;

   // grid limits
   localparam int unsigned MAX_COLUMNS = 256;
   localparam int unsigned MAX_ROWS    = 256;

   // character codes
   localparam logic [7:0] CODE_BACKSPACE = 8'h7f;
   localparam logic [7:0] CODE_NEWLINE   = 8'h0a;
   localparam logic [7:0] CODE_SPACE     = 8'h20;

   // register reset values
   localparam logic [8:0]  RESET_COLUMNS = 9'd128;
   localparam logic [8:0]  RESET_ROWS    = 9'd96;
   localparam logic [29:0] RESET_BASE    = 30'd0;

   // front-to-back queue
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

   typedef enum logic [1:0] {
      OP_PUT   = 2'd0,
      OP_SET   = 2'd1,
      OP_CLEAR = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      CMD_PLOT   = 2'd0,
      CMD_SCROLL = 2'd1,
      CMD_CLEAR  = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      REG_COLUMNS = 2'd0,
      REG_ROWS    = 2'd1,
      REG_BASE    = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] char_code;
      logic [7:0] col_in;
      logic [7:0] row_in;
   } req_word_type;

   typedef struct packed {
      logic [1:0]  command;
      logic [7:0]  glyph;
      logic [7:0]  cell_col;
      logic [7:0]  cell_row;
      logic [31:0] cell_address;
      logic        last;
   } rsp_word_type;

   // classified work for one input: an optional plot, then an optional scroll or clear
   typedef struct packed {
      logic       plot_valid;
      logic [7:0] glyph;
      logic [7:0] col;
      logic [7:0] row;
      logic       tail_valid;
      cmd_type    tail_cmd;
   } entry_type;

   // settings the back end needs for addressing
   typedef struct packed {
      logic [7:0]  cols_last;
      logic [29:0] frame_base;
   } cfg_type;

   // last valid index of a grid dimension, register value saturated to 1..limit
   function automatic logic [7:0] sat_last(input logic [8:0] v, input logic [8:0] limit);
      logic [8:0] d;
      begin
         if (v == 9'd0) begin
            d = 9'd0;
         end else if (v > limit) begin
            d = limit - 9'd1;
         end else begin
            d = v - 9'd1;
         end
         sat_last = d[7:0];
      end
   endfunction

   function automatic logic [7:0] min8(input logic [7:0] a, input logic [7:0] b);
      min8 = (a > b) ? b : a;
   endfunction

endpackage

`default_nettype wire

### hdl/tcce_front.sv
// front end: settings, cursor state and classification of input words
`default_nettype none

module tcce_front import tcce_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   output logic              full,
   input  wire req_word_type req_word,
   input  wire logic         csr_write_en,
   input  wire logic [1:0]   csr_index,
   input  wire logic [29:0]  csr_data,
   input  wire logic         q_full,
   output logic              q_push,
   output entry_type         q_entry,
   output cfg_type           cfg
);

   logic [7:0]  cols_last_ff, cols_last_in;
   logic [7:0]  rows_last_ff, rows_last_in;
   logic [29:0] base_ff, base_in;
   logic [7:0]  cursor_col_ff, cursor_col_in;
   logic [7:0]  cursor_row_ff, cursor_row_in;

   logic      accept;
   entry_type entry;
   logic [7:0] nc, nr;

   assign full   = q_full;
   assign accept = push && !q_full;

   // classify the word and work out the next cursor
   always_comb begin
      entry            = '0;
      entry.tail_cmd   = CMD_SCROLL;
      nc               = cursor_col_ff;
      nr               = cursor_row_ff;
      case (op_type'(req_word.op))
         OP_PUT: begin
            if (req_word.char_code == CODE_BACKSPACE) begin
               if (cursor_col_ff == 8'd0) begin
                  nc = cols_last_ff;
                  nr = (cursor_row_ff != 8'd0) ? cursor_row_ff - 8'd1 : 8'd0;
               end else begin
                  nc = cursor_col_ff - 8'd1;
               end
               entry.plot_valid = 1'b1;
               entry.glyph      = CODE_SPACE;
               entry.col        = nc;
               entry.row        = nr;
            end else if (req_word.char_code == CODE_NEWLINE) begin
               nc = 8'd0;
               if (cursor_row_ff == rows_last_ff) begin
                  entry.tail_valid = 1'b1;
               end else begin
                  nr = cursor_row_ff + 8'd1;
               end
            end else begin
               entry.plot_valid = 1'b1;
               entry.glyph      = req_word.char_code;
               entry.col        = cursor_col_ff;
               entry.row        = cursor_row_ff;
               if (cursor_col_ff == cols_last_ff) begin
                  nc = 8'd0;
                  if (cursor_row_ff == rows_last_ff) begin
                     entry.tail_valid = 1'b1;
                  end else begin
                     nr = cursor_row_ff + 8'd1;
                  end
               end else begin
                  nc = cursor_col_ff + 8'd1;
               end
            end
         end
         OP_SET: begin
            nc = min8(req_word.col_in, cols_last_ff);
            nr = min8(req_word.row_in, rows_last_ff);
         end
         OP_CLEAR: begin
            nc               = 8'd0;
            nr               = 8'd0;
            entry.tail_valid = 1'b1;
            entry.tail_cmd   = CMD_CLEAR;
         end
         default: begin
         end
      endcase
   end

   assign q_push  = accept && (entry.plot_valid || entry.tail_valid);
   assign q_entry = entry;

   // settings writes pull the cursor back into the grid
   always_comb begin
      cols_last_in  = cols_last_ff;
      rows_last_in  = rows_last_ff;
      base_in       = base_ff;
      cursor_col_in = cursor_col_ff;
      cursor_row_in = cursor_row_ff;
      if (csr_write_en) begin
         case (reg_index_type'(csr_index))
            REG_COLUMNS: cols_last_in = sat_last(csr_data[8:0], 9'(MAX_COLUMNS));
            REG_ROWS:    rows_last_in = sat_last(csr_data[8:0], 9'(MAX_ROWS));
            REG_BASE:    base_in      = csr_data;
            default: begin
            end
         endcase
         cursor_col_in = min8(cursor_col_ff, cols_last_in);
         cursor_row_in = min8(cursor_row_ff, rows_last_in);
      end else if (accept) begin
         cursor_col_in = nc;
         cursor_row_in = nr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_last_ff  <= sat_last(RESET_COLUMNS, 9'(MAX_COLUMNS));
         rows_last_ff  <= sat_last(RESET_ROWS, 9'(MAX_ROWS));
         base_ff       <= RESET_BASE;
         cursor_col_ff <= 8'd0;
         cursor_row_ff <= 8'd0;
      end else begin
         cols_last_ff  <= cols_last_in;
         rows_last_ff  <= rows_last_in;
         base_ff       <= base_in;
         cursor_col_ff <= cursor_col_in;
         cursor_row_ff <= cursor_row_in;
      end
   end

   assign cfg.cols_last  = cols_last_ff;
   assign cfg.frame_base = base_ff;

`ifndef SYNTHESIS
   // cursor never leaves the grid
   a_cursor_in_grid: assert property (@(posedge clock) disable iff (reset)
      (cursor_col_ff <= cols_last_ff) && (cursor_row_ff <= rows_last_ff))
      else $error("cursor outside grid");
`endif

endmodule

`default_nettype wire

### hdl/tcce_queue.sv
// short queue of classified entries between front and back end
`default_nettype none

module tcce_queue import tcce_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      q_push,
   input  wire entry_type q_entry,
   output logic           q_full,
   output logic           q_valid,
   output entry_type      q_head,
   input  wire logic      q_pop
);

   localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

   entry_type             slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ff, wr_in;
   logic [QUEUE_AW-1:0]   rd_ff, rd_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  do_push, do_pop;

   assign q_full  = (cnt_ff == CW'(QUEUE_DEPTH));
   assign q_valid = (cnt_ff != '0);
   assign q_head  = slot_ff[rd_ff];
   assign do_push = q_push && !q_full;
   assign do_pop  = q_pop && q_valid;

   // pointer and fill count
   always_comb begin
      wr_in  = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= q_entry;
      end
   end

`ifndef SYNTHESIS
   // the front end never offers an entry to a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_full))
      else $error("push into full queue");
   // fill count stays within depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(QUEUE_DEPTH))
      else $error("queue count out of range");
`endif

endmodule

`default_nettype wire

### hdl/tcce_back.sv
// back end: expands queue entries into result words and buffers them
`default_nettype none

module tcce_back import tcce_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire cfg_type   cfg,
   input  wire logic      q_valid,
   input  wire entry_type q_head,
   output logic           q_pop,
   output logic           empty,
   input  wire logic      pop,
   output rsp_word_type   rsp_word
);

   rsp_word_type ob_ff [2];
   logic         ob_wr_ff, ob_wr_in;
   logic         ob_rd_ff, ob_rd_in;
   logic [1:0]   ob_cnt_ff, ob_cnt_in;
   logic         phase_ff, phase_in;

   logic         out_take, space, fire, use_plot;
   logic [16:0]  row_span;
   rsp_word_type word;

   assign out_take = pop && (ob_cnt_ff != 2'd0);
   assign space    = (ob_cnt_ff != 2'd2) || out_take;
   assign fire     = q_valid && space;
   assign use_plot = q_head.plot_valid && !phase_ff;
   assign row_span = 17'(q_head.row) * ({1'b0, cfg.cols_last} + 9'd1);

   // build the next result word
   always_comb begin
      word = '0;
      if (use_plot) begin
         word.command      = CMD_PLOT;
         word.glyph        = q_head.glyph;
         word.cell_col     = q_head.col;
         word.cell_row     = q_head.row;
         word.cell_address = {2'b00, cfg.frame_base}
                           + {7'd0, row_span, 8'd0}
                           + {19'd0, q_head.col, 5'd0};
         word.last         = !q_head.tail_valid;
      end else begin
         word.command = q_head.tail_cmd;
         word.last    = 1'b1;
      end
   end

   assign q_pop = fire && word.last;

   // sequencing and output buffer control
   always_comb begin
      phase_in  = phase_ff;
      ob_wr_in  = ob_wr_ff;
      ob_rd_in  = out_take ? !ob_rd_ff : ob_rd_ff;
      ob_cnt_in = ob_cnt_ff;
      if (fire) begin
         phase_in = !word.last;
         ob_wr_in = !ob_wr_ff;
      end
      if (fire && !out_take) begin
         ob_cnt_in = ob_cnt_ff + 2'd1;
      end else if (out_take && !fire) begin
         ob_cnt_in = ob_cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= 1'b0;
         ob_wr_ff  <= 1'b0;
         ob_rd_ff  <= 1'b0;
         ob_cnt_ff <= 2'd0;
      end else begin
         phase_ff  <= phase_in;
         ob_wr_ff  <= ob_wr_in;
         ob_rd_ff  <= ob_rd_in;
         ob_cnt_ff <= ob_cnt_in;
      end
   end

   // output word storage
   always_ff @(posedge clock) begin
      if (fire) begin
         ob_ff[ob_wr_ff] <= word;
      end
   end

   assign empty    = (ob_cnt_ff == 2'd0);
   assign rsp_word = ob_ff[ob_rd_ff];

`ifndef SYNTHESIS
   // second half of an entry is only pending for an entry with plot and tail
   a_phase_pair: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> (q_valid && q_head.plot_valid && q_head.tail_valid))
      else $error("tail phase without paired entry");
   // output buffer holds at most two words
   a_ob_bound: assert property (@(posedge clock) disable iff (reset)
      ob_cnt_ff != 2'd3)
      else $error("output buffer overrun");
`endif

endmodule

`default_nettype wire

### hdl/text_console_cursor_engine_unit.sv
// top level of the text console cursor engine
//
// Usage: input words (op, char_code, col_in, row_in) enter through push/full
// like a queue write; an input word is taken at an edge with push high and
// full low. Result words (command, glyph, cell, address, last) leave through
// empty/pop: the oldest word is on rsp_word while empty is low and leaves at
// an edge with pop high. Each input word yields zero, one or two result
// words; the final one of a group carries last.
// Path: an input word is registered in the queue, and its result words in
// the output buffer, from which rsp_word is read.
// Throughput: one input word per cycle while full is low; the back end, while
// its output buffer has room, emits one result word per cycle, so a plot and a
// scroll need two of them; a four-entry front-to-back queue absorbs the difference.
// Settings are written through csr_write_en/csr_index/csr_data; the user must
// write only while idle (unchecked here); a write pulls the cursor back into the grid.
// Reset: synchronous; cursor at home, 128 by 96 grid, base 0, all empty.
// When the receiver stops popping, the output buffer then the queue fill
// and full rises; nothing is dropped.
`default_nettype none

module text_console_cursor_engine_unit import tcce_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   output logic              full,
   input  wire req_word_type req_word,
   output logic              empty,
   input  wire logic         pop,
   output rsp_word_type      rsp_word,
   input  wire logic         csr_write_en,
   input  wire logic [1:0]   csr_index,
   input  wire logic [29:0]  csr_data
);

   logic      q_push, q_full, q_valid, q_pop;
   entry_type q_entry, q_head;
   cfg_type   cfg;

   // cursor and classification
   tcce_front u_front (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .full         (full),
      .req_word     (req_word),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_entry      (q_entry),
      .cfg          (cfg)
   );

   // decoupling queue
   tcce_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .q_push  (q_push),
      .q_entry (q_entry),
      .q_full  (q_full),
      .q_valid (q_valid),
      .q_head  (q_head),
      .q_pop   (q_pop)
   );

   // result word generation
   tcce_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .q_valid  (q_valid),
      .q_head   (q_head),
      .q_pop    (q_pop),
      .empty    (empty),
      .pop      (pop),
      .rsp_word (rsp_word)
   );

endmodule

`default_nettype wire
